>>> rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types, codes and prefix tables of the response header parser
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int FIFO_DEPTH_DEF  = 2;

    localparam int COL_BITS   = 6;
    localparam int COLUMN_MAX = 63;

    // prefix lengths; HTTP_LEN and CLEN_LEN are also the columns where numbers start
    localparam int HTTP_LEN  = 9;
    localparam int CLEN_LEN  = 15;
    localparam int CHUNK_LEN = 26;

    localparam logic [8*HTTP_LEN-1:0]  PFX_HTTP10 = "HTTP/1.0 ";
    localparam logic [8*HTTP_LEN-1:0]  PFX_HTTP11 = "HTTP/1.1 ";
    localparam logic [8*CLEN_LEN-1:0]  PFX_CLEN   = "content-length:";
    localparam logic [8*CHUNK_LEN-1:0] PFX_CHUNK  = "transfer-encoding: chunked";

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam int STATUS_INFO_LO = 100;
    localparam int STATUS_INFO_HI = 200;

    // parse phases
    localparam logic [1:0] PHASE_HEADERS = 2'd0;
    localparam logic [1:0] PHASE_DONE    = 2'd1;
    localparam logic [1:0] PHASE_ERROR   = 2'd2;

    // number scanner stages
    localparam logic [1:0] NUM_BEFORE = 2'd0;
    localparam logic [1:0] NUM_DIGITS = 2'd1;
    localparam logic [1:0] NUM_GOOD   = 2'd2;
    localparam logic [1:0] NUM_BAD    = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_PROTOCOL = 3'd1;
    localparam logic [2:0] ERR_STATUS   = 3'd2;
    localparam logic [2:0] ERR_BADLEN   = 3'd3;
    localparam logic [2:0] ERR_DUPLEN   = 3'd4;
    localparam logic [2:0] ERR_CHUNKED  = 3'd5;

    // input kinds
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    // one classified byte, handed from front to back
    typedef struct packed {
        logic       restart;
        logic       is_lf;
        logic [3:0] mismatch;     // per prefix: this byte breaks the match
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
        logic       col_ge_status;
        logic       col_ge_length;
        logic       len_zero;     // line ends empty (lf only)
        logic       len_ge_http;
        logic       len_ge_clen;
        logic       len_ge_chunk;
    } hrp_class_t;

    // expected prefix character; k selects the prefix
    function automatic logic [7:0] pfx_char(input logic [1:0] k,
                                            input logic [COL_BITS-1:0] col);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0: if (int'(col) < HTTP_LEN)
                      ch = PFX_HTTP10[8*(HTTP_LEN-1-int'(col)) +: 8];
            2'd1: if (int'(col) < HTTP_LEN)
                      ch = PFX_HTTP11[8*(HTTP_LEN-1-int'(col)) +: 8];
            2'd2: if (int'(col) < CLEN_LEN)
                      ch = PFX_CLEN[8*(CLEN_LEN-1-int'(col)) +: 8];
            2'd3: if (int'(col) < CHUNK_LEN)
                      ch = PFX_CHUNK[8*(CHUNK_LEN-1-int'(col)) +: 8];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic int pfx_len(input logic [1:0] k);
        int n;
        case (k)
            2'd0:    n = HTTP_LEN;
            2'd1:    n = HTTP_LEN;
            2'd2:    n = CLEN_LEN;
            2'd3:    n = CHUNK_LEN;
            default: n = 0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/hrp_front.sv
// ----------------------------------------------------------------------------
// hrp_front
// accepts input transactions, tracks the line column and classifies bytes
// ----------------------------------------------------------------------------
module hrp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               q_full,
    output logic               q_push,
    output hrp_pkg::hrp_class_t q_entry
);
    import hrp_pkg::*;

    logic [COL_BITS-1:0] column_reg, column_next;
    logic                saw_cr_reg, saw_cr_next;
    logic                accept;
    logic [7:0]          b;
    logic [7:0]          b_low;
    logic [COL_BITS-1:0] line_len;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;
    assign b        = s_tdata;
    assign b_low    = (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
    // a cr right before the lf is not part of the line
    assign line_len = (saw_cr_reg && column_reg != '0) ? (column_reg - 1'b1) : column_reg;

    always_comb begin
        q_entry          = '0;
        q_entry.restart  = (s_tuser[0] == ACT_RESTART);
        q_entry.is_lf    = (b == CHAR_LF);
        for (int k = 0; k < 4; k++) begin
            if (int'(column_reg) < pfx_len(2'(k))) begin
                q_entry.mismatch[k] = ((k >= 2) ? b_low : b) != pfx_char(2'(k), column_reg);
            end
        end
        q_entry.is_space      = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) ||
                                (b == 8'h0C) || (b == CHAR_CR);
        q_entry.is_digit      = (b >= 8'h30) && (b <= 8'h39);
        q_entry.digit         = 4'(b - 8'h30);
        q_entry.col_ge_status = int'(column_reg) >= HTTP_LEN;
        q_entry.col_ge_length = int'(column_reg) >= CLEN_LEN;
        q_entry.len_zero      = (line_len == '0);
        q_entry.len_ge_http   = int'(line_len) >= HTTP_LEN;
        q_entry.len_ge_clen   = int'(line_len) >= CLEN_LEN;
        q_entry.len_ge_chunk  = int'(line_len) >= CHUNK_LEN;
    end

    always_comb begin
        column_next = column_reg;
        saw_cr_next = saw_cr_reg;
        if (accept) begin
            if (s_tuser[0] == ACT_RESTART || b == CHAR_LF) begin
                column_next = '0;
                saw_cr_next = 1'b0;
            end else begin
                if (int'(column_reg) < COLUMN_MAX) begin
                    column_next = column_reg + 1'b1;
                end
                saw_cr_next = (b == CHAR_CR);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            saw_cr_reg <= 1'b0;
        end else begin
            column_reg <= column_next;
            saw_cr_reg <= saw_cr_next;
        end
    end

endmodule

>>> rtl/hrp_fifo.sv
// ----------------------------------------------------------------------------
// hrp_fifo
// short register queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module hrp_fifo #(
    parameter int DEPTH = hrp_pkg::FIFO_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hrp_pkg::hrp_class_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output hrp_pkg::hrp_class_t head
);
    import hrp_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    hrp_class_t          entries_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !(push && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue read while empty");

endmodule

>>> rtl/hrp_back.sv
// ----------------------------------------------------------------------------
// hrp_back
// header state, number scanning, line end checks and the result register
// ----------------------------------------------------------------------------
module hrp_back #(
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  hrp_pkg::hrp_class_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata
);
    import hrp_pkg::*;

    localparam int LB = LENGTH_BITS;

    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    flags_reg, flags_next;
    logic [1:0]    stage_reg, stage_next;
    logic [LB-1:0] accum_reg, accum_next;
    logic [15:0]   status_reg, status_next;
    logic [LB-1:0] length_reg, length_next;
    logic          seen_reg, seen_next;
    logic [2:0]    error_reg, error_next;
    logic          out_valid_reg;
    logic [55:0]   out_data_reg, out_data_next;

    hrp_class_t    e;
    logic          status_mode;
    logic          feed;
    logic          num_ok;
    logic [LB+3:0] cap;
    logic [LB+3:0] prod;
    logic [LB+31:0] length_wide;

    assign e           = q_head;
    assign q_pop       = !q_empty && (!out_valid_reg || m_tready);
    assign status_mode = (status_reg == '0);
    assign feed        = status_mode ? e.col_ge_status : e.col_ge_length;
    assign num_ok      = (stage_reg == NUM_DIGITS) || (stage_reg == NUM_GOOD);
    assign cap         = status_mode ? {{(LB - 12){1'b0}}, 16'hFFFF} : {4'b0, {LB{1'b1}}};
    // accum * 10 + digit, never wider than LB + 4 bits since accum <= cap
    assign prod        = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0} +
                         {{LB{1'b0}}, e.digit};

    always_comb begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        stage_next  = stage_reg;
        accum_next  = accum_reg;
        status_next = status_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        error_next  = error_reg;
        if (q_pop) begin
            if (e.restart) begin
                phase_next  = PHASE_HEADERS;
                flags_next  = 4'hF;
                stage_next  = NUM_BEFORE;
                accum_next  = '0;
                status_next = '0;
                length_next = '0;
                seen_next   = 1'b0;
                error_next  = ERR_NONE;
            end else if (phase_reg == PHASE_HEADERS) begin
                if (e.is_lf) begin
                    // line end checks
                    if (e.len_zero) begin
                        phase_next = PHASE_DONE;
                    end else if (status_mode) begin
                        if (!(flags_reg[1:0] != 2'b00 && e.len_ge_http)) begin
                            phase_next = PHASE_ERROR;
                            error_next = ERR_PROTOCOL;
                        end else if (!num_ok || accum_reg == '0) begin
                            phase_next = PHASE_ERROR;
                            error_next = ERR_STATUS;
                        end else if (!(accum_reg >= LB'(STATUS_INFO_LO) &&
                                       accum_reg < LB'(STATUS_INFO_HI))) begin
                            status_next = accum_reg[15:0];
                        end
                    end else if (flags_reg[2] && e.len_ge_clen) begin
                        if (!num_ok) begin
                            phase_next = PHASE_ERROR;
                            error_next = ERR_BADLEN;
                        end else if (seen_reg && accum_reg != length_reg) begin
                            phase_next = PHASE_ERROR;
                            error_next = ERR_DUPLEN;
                        end else begin
                            length_next = accum_reg;
                            seen_next   = 1'b1;
                        end
                    end else if (flags_reg[3] && e.len_ge_chunk) begin
                        phase_next = PHASE_ERROR;
                        error_next = ERR_CHUNKED;
                    end
                    flags_next = 4'hF;
                    stage_next = NUM_BEFORE;
                    accum_next = '0;
                end else begin
                    flags_next = flags_reg & ~e.mismatch;
                    if (feed) begin
                        case (stage_reg)
                            NUM_BEFORE: begin
                                if (e.is_digit) begin
                                    accum_next = {{(LB - 4){1'b0}}, e.digit};
                                    stage_next = NUM_DIGITS;
                                end else if (!e.is_space) begin
                                    stage_next = NUM_BAD;
                                end
                            end
                            NUM_DIGITS: begin
                                if (e.is_digit) begin
                                    accum_next = (prod > cap) ? cap[LB-1:0] : prod[LB-1:0];
                                end else if (e.is_space) begin
                                    stage_next = NUM_GOOD;
                                end else begin
                                    stage_next = NUM_BAD;
                                end
                            end
                            default: begin
                                stage_next = stage_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    assign length_wide = {32'b0, length_next};

    always_comb begin
        out_data_next        = '0;
        out_data_next[1:0]   = phase_next;
        out_data_next[4:2]   = (phase_next == PHASE_ERROR) ? error_next : ERR_NONE;
        out_data_next[20:5]  = status_next;
        out_data_next[52:21] = length_wide[31:0];
        out_data_next[53]    = seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_HEADERS;
            flags_reg     <= 4'hF;
            stage_reg     <= NUM_BEFORE;
            accum_reg     <= '0;
            status_reg    <= '0;
            length_reg    <= '0;
            seen_reg      <= 1'b0;
            error_reg     <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            stage_reg  <= stage_next;
            accum_reg  <= accum_next;
            status_reg <= status_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            error_reg  <= error_next;
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("unused phase code reached");

    a_status_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg != '0 && !(q_pop && e.restart)) |=> status_reg != '0)
        else $error("status lost without restart");

    a_length_after_status: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> status_reg != '0)
        else $error("length recorded before a status");

    a_frozen_when_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PHASE_HEADERS && !(q_pop && e.restart)) |=>
            $stable(phase_reg) && $stable(length_reg) && $stable(status_reg))
        else $error("state moved after the headers ended");

endmodule

>>> rtl/http_response_header_parser.sv
// ----------------------------------------------------------------------------
// http_response_header_parser
// byte-wide http/1.0 and http/1.1 response header parser with one result per byte
// ----------------------------------------------------------------------------
// usage:
//   the slave stream takes one transaction per response byte; s_tuser[0]
//   selects the kind (0 = data byte in s_tdata, 1 = restart for a new
//   response). every accepted transaction gives exactly one result on the
//   master stream: phase (still in headers, complete, error), error code,
//   final status code, declared content length and a length-known flag.
//   a front stage classifies each byte against the line column it tracks,
//   a two-entry queue holds classified bytes, and a back stage runs the
//   header state and owns the result register.
//   the queue is written at the accepting edge and the back stage then loads
//   the result register from the queue head; throughput is one byte per clock
//   while m_tready does not hold the result register.
//   when m_tready is low the result register holds, the queue fills and
//   s_tready drops once it is full; nothing is dropped.
//   aresetn (synchronous, active low) empties the queue, clears the result
//   valid and returns the parser to the start of a response.
// ----------------------------------------------------------------------------
module http_response_header_parser #(
    parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF,
    parameter int FIFO_DEPTH  = hrp_pkg::FIFO_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [1:0] event_res, [4:2] error_code,
                                   // [20:5] status_value, [52:21] body_length,
                                   // [53] length_known, [55:54] zero
);
    import hrp_pkg::*;

    // classified byte path between front and back
    hrp_class_t push_entry;
    hrp_class_t head_entry;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    // front: handshake, column tracking, prefix and character classes
    hrp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // queue lets the front keep taking bytes while a result waits
    hrp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head_entry)
    );

    // back: header state machine and result register
    hrp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the http response header parser: a queue-fed
// stream driver, a result monitor and a bit-exact parser predictor, run
// through directed bytes and generated responses under varying back-pressure
// ----------------------------------------------------------------------------
module tb_top;
    import hrp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_TAIL  = 16;
    localparam int PRINT_LIMIT = 30;

    localparam logic [31:0] STATUS_CAP = 32'd65535;
    localparam logic [31:0] LENGTH_CAP = 32'hFFFF_FFFF;

    // prefixes matched at the start of each line
    localparam bit [8*HTTP_LEN-1:0]  TXT_HTTP10 = "HTTP/1.0 ";
    localparam bit [8*HTTP_LEN-1:0]  TXT_HTTP11 = "HTTP/1.1 ";
    localparam bit [8*CLEN_LEN-1:0]  TXT_CLEN   = "content-length:";
    localparam bit [8*CHUNK_LEN-1:0] TXT_CHUNK  = "transfer-encoding: chunked";

    // one input transaction
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } parser_in_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  event_res;
        logic [2:0]  error_code;
        logic [15:0] status_value;
        logic [31:0] body_length;
        logic        length_known;
    } parser_out_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_tuser  = 1'b0;    // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;            // [1:0] event_res, [4:2] error_code,
                                     // [20:5] status_value, [52:21] body_length,
                                     // [53] length_known, [55:54] zero

    http_response_header_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // stimulus and scoreboard storage
    parser_in_t  byte_stream[$];         // transactions waiting for the driver
    parser_out_t header_results_due[$];  // predicted results, oldest first
    parser_in_t  offered;                // transaction currently on the bus

    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    hold_asked     = 0;
    int    hold_taken     = 0;
    int    hold_left      = 0;
    int    mismatch_count = 0;
    int    result_count   = 0;
    int    cycle_count    = 0;
    string last_len_text  = "";

    // predictor state
    logic [1:0]  phase_now;
    logic [5:0]  line_col;
    logic [3:0]  prefix_live;        // one bit per prefix still matching
    logic [1:0]  num_stage;
    logic [31:0] num_value;
    logic        ends_in_cr;
    logic [15:0] status_code;
    logic [31:0] content_len;
    logic        content_len_seen;
    logic [2:0]  error_kind;

    // ------------------------------------------------------------------------
    // parser predictor
    // ------------------------------------------------------------------------

    function automatic void clear_line_state();
        line_col    = '0;
        prefix_live = 4'hF;
        num_stage   = NUM_BEFORE;
        num_value   = '0;
        ends_in_cr  = 1'b0;
    endfunction

    function automatic void restart_parser();
        phase_now = PHASE_HEADERS;
        clear_line_state();
        status_code      = '0;
        content_len      = '0;
        content_len_seen = 1'b0;
        error_kind       = ERR_NONE;
    endfunction

    function automatic int prefix_span(input int k);
        case (k)
            0, 1:    return HTTP_LEN;
            2:       return CLEN_LEN;
            default: return CHUNK_LEN;
        endcase
    endfunction

    // caller guarantees col is inside the prefix
    function automatic logic [7:0] prefix_char_at(input int k, input int col);
        case (k)
            0:       return TXT_HTTP10[8*(HTTP_LEN-1-col) +: 8];
            1:       return TXT_HTTP11[8*(HTTP_LEN-1-col) +: 8];
            2:       return TXT_CLEN[8*(CLEN_LEN-1-col) +: 8];
            default: return TXT_CHUNK[8*(CHUNK_LEN-1-col) +: 8];
        endcase
    endfunction

    // space, tab, vt, ff and cr all separate numbers
    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == CHAR_CR;
    endfunction

    function automatic void scan_number(input logic [7:0] b, input logic [31:0] cap);
        logic        digit;
        logic [31:0] d;
        digit = (b >= "0") && (b <= "9");
        d     = {24'd0, b} - 32'h30;
        case (num_stage)
            NUM_BEFORE: begin
                if (digit) begin
                    num_value = d;
                    num_stage = NUM_DIGITS;
                end else if (!is_blank(b)) begin
                    num_stage = NUM_BAD;
                end
            end
            NUM_DIGITS: begin
                if (digit) begin
                    // saturate rather than wrap
                    if (num_value > (cap - d) / 32'd10) begin
                        num_value = cap;
                    end else begin
                        num_value = num_value * 32'd10 + d;
                    end
                end else if (is_blank(b)) begin
                    num_stage = NUM_GOOD;
                end else begin
                    num_stage = NUM_BAD;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void flag_error(input logic [2:0] code);
        phase_now  = PHASE_ERROR;
        error_kind = code;
    endfunction

    // judge a complete line at its lf
    function automatic void finish_line();
        int   len;
        logic num_ok;
        len    = line_col;
        num_ok = (num_stage == NUM_DIGITS) || (num_stage == NUM_GOOD);
        if (ends_in_cr && len > 0) begin
            len--;
        end
        if (len == 0) begin
            phase_now = PHASE_DONE;
        end else if (status_code == 0) begin
            if (prefix_live[1:0] == 2'b00 || len < HTTP_LEN) begin
                flag_error(ERR_PROTOCOL);
            end else if (!num_ok || num_value == 0) begin
                flag_error(ERR_STATUS);
            end else if (!(num_value >= STATUS_INFO_LO && num_value < STATUS_INFO_HI)) begin
                // informational codes are skipped, anything else is final
                status_code = num_value[15:0];
            end
        end else if (prefix_live[2] && len >= CLEN_LEN) begin
            if (!num_ok) begin
                flag_error(ERR_BADLEN);
            end else if (content_len_seen && num_value != content_len) begin
                flag_error(ERR_DUPLEN);
            end else begin
                content_len      = num_value;
                content_len_seen = 1'b1;
            end
        end else if (prefix_live[3] && len >= CHUNK_LEN) begin
            flag_error(ERR_CHUNKED);
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic       status_mode;
        logic [7:0] c;
        int         k;
        status_mode = (status_code == 0);
        if (b == CHAR_LF) begin
            finish_line();
            clear_line_state();
        end else begin
            for (k = 0; k < 4; k++) begin
                if (int'(line_col) < prefix_span(k)) begin
                    c = b;
                    // header prefixes ignore case, status prefixes do not
                    if (k >= 2 && c >= "A" && c <= "Z") begin
                        c = c + 8'h20;
                    end
                    if (c != prefix_char_at(k, int'(line_col))) begin
                        prefix_live[k] = 1'b0;
                    end
                end
            end
            if (status_mode) begin
                if (line_col >= HTTP_LEN) begin
                    scan_number(b, STATUS_CAP);
                end
            end else if (line_col >= CLEN_LEN) begin
                scan_number(b, LENGTH_CAP);
            end
            if (line_col < COLUMN_MAX) begin
                line_col++;
            end
            ends_in_cr = (b == CHAR_CR);
        end
    endfunction

    function automatic parser_out_t parse_header_byte(input parser_in_t item);
        parser_out_t r;
        if (item.action == ACT_RESTART) begin
            restart_parser();
        end else if (phase_now == PHASE_HEADERS) begin
            absorb_byte(item.data_byte);
        end
        r.event_res    = phase_now;
        r.error_code   = (phase_now == PHASE_ERROR) ? error_kind : ERR_NONE;
        r.status_value = status_code;
        r.body_length  = content_len;
        r.length_known = content_len_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // response generation
    // ------------------------------------------------------------------------

    task automatic push_item(input logic act, input logic [7:0] b);
        parser_in_t t;
        t.action    = act;
        t.data_byte = b;
        byte_stream.push_back(t);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            push_item(ACT_BYTE, s[i]);
        end
    endtask

    // mostly crlf, sometimes a bare lf
    task automatic end_line();
        if ($urandom_range(3) != 0) begin
            push_item(ACT_BYTE, CHAR_CR);
        end
        push_item(ACT_BYTE, CHAR_LF);
    endtask

    // any byte but lf, so the line keeps going
    task automatic push_junk(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(255));
            push_item(ACT_BYTE, (b == CHAR_LF) ? 8'hAA : b);
        end
    endtask

    function automatic string mix_case(input string s);
        string      t;
        logic [7:0] c;
        int         i;
        t = s;
        for (i = 0; i < t.len(); i++) begin
            c = t[i];
            if (c >= "a" && c <= "z" && $urandom_range(1) == 1) begin
                t[i] = c - 8'h20;
            end
        end
        return t;
    endfunction

    // up to most whitespace characters, spaces favored
    function automatic string blank_run(input int most);
        string      s;
        logic [7:0] w;
        int         n;
        int         i;
        s = "";
        n = $urandom_range(most);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(7))
                0:       w = 8'h09;
                1:       w = 8'h0B;
                2:       w = 8'h0C;
                3:       w = CHAR_CR;
                default: w = 8'h20;
            endcase
            s = {s, $sformatf("%c", w)};
        end
        return s;
    endfunction

    task automatic queue_status_line();
        string ver;
        string code;
        int    pick;
        ver  = ($urandom_range(1) == 1) ? "HTTP/1.1 " : "HTTP/1.0 ";
        code = $sformatf("%0d", $urandom_range(1, 999));
        pick = $urandom_range(99);
        if (pick < 45) begin
            case ($urandom_range(4))
                0:       code = "200";
                1:       code = "204";
                2:       code = "301";
                3:       code = "404";
                default: code = "500";
            endcase
        end else if (pick < 60) begin
            // keep the random code
        end else if (pick < 65) begin
            code = "65535";
        end else if (pick < 69) begin
            code = "7000000";                   // saturates the status
        end else if (pick < 72) begin
            code = "0";
        end else if (pick < 75) begin
            code = {"00", code};
        end else if (pick < 78) begin
            code = ($urandom_range(1) == 1) ? "+200" : "-200";
        end else if (pick < 81) begin
            code = "";                          // no digits at all
        end else if (pick < 84) begin
            code = {code, "x"};                 // junk glued to the digits
        end else if (pick < 87) begin
            ver = "http/1.1 ";                  // status prefix is case exact
        end else if (pick < 90) begin
            ver = "HTTP/2.0 ";
        end else if (pick < 93) begin
            ver  = "HTTP/1.1";                  // short line
            code = "";
        end
        push_text({ver, blank_run(2), code});
        case ($urandom_range(2))
            0:       push_text(" OK");
            1:       push_text("\tFine");
            default: begin
            end
        endcase
        end_line();
    endtask

    task automatic queue_header_line();
        string num;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            case ($urandom_range(9))
                0:       num = "0";
                1:       num = "4294967295";
                2:       num = "4294967296";
                3:       num = "98765432109876";
                4:       num = ($urandom_range(1) == 1) ? "+5" : "-5";
                5:       num = "";
                6:       num = "12a";
                default: num = $sformatf("%0d", $urandom_range(0, 99999));
            endcase
            last_len_text = num;
            push_text({mix_case("content-length:"), blank_run(2), num, blank_run(1)});
        end else if (pick < 35) begin
            // repeated length: same value or a different one
            num = (last_len_text == "" || $urandom_range(1) == 1) ?
                  $sformatf("%0d", $urandom_range(0, 99)) : last_len_text;
            push_text({mix_case("content-length: "), num});
        end else if (pick < 45) begin
            case ($urandom_range(3))
                0:       push_text(mix_case("transfer-encoding: chunked"));
                1:       push_text({mix_case("transfer-encoding: chunked"), ", gzip"});
                2:       push_text("Transfer-Encoding: identity");
                default: push_text("transfer-encoding: chunk");
            endcase
        end else if (pick < 52) begin
            case ($urandom_range(2))
                0:       push_text("content-lengt: 5");
                1:       push_text("Content-Length 5");
                default: push_text("Xcontent-length: 9");
            endcase
        end else begin
            push_text("X-Note: ");
            // mostly short values, a few run past the column limit
            push_junk(($urandom_range(9) != 0) ? $urandom_range(0, 12) : $urandom_range(40, 70));
        end
        end_line();
    endtask

    task automatic queue_response();
        int pick;
        int n;
        push_item(ACT_RESTART, 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 6) begin
            // pure noise
            n = $urandom_range(1, 12);
            repeat (n) push_item(ACT_BYTE, 8'($urandom_range(255)));
        end else begin
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) begin
                push_text({"HTTP/1.1 ", $sformatf("%0d", $urandom_range(100, 199)),
                           " Continue"});
                end_line();
            end
            // a few responses never send a final status
            if (pick >= 10) begin
                queue_status_line();
            end
            n = $urandom_range(0, 3);
            repeat (n) queue_header_line();
            if ($urandom_range(9) != 0) begin
                end_line();
            end
            // trailing bytes after the headers are ignored
            n = $urandom_range(0, 2);
            repeat (n) push_item(ACT_BYTE, 8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                     $realtime, result_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------------

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the stream wedges
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("http_response_header_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: predicts on each accepted transaction, then offers the next
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                header_results_due.push_back(parse_header_byte(offered));
            end
            // bus is free when nothing is offered or the offer was just taken
            if (!s_tvalid || s_tready) begin
                if (byte_stream.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered  = byte_stream.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.data_byte;
                    s_tuser  <= offered.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls plus a long hold-off on request
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_taken != hold_asked) begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        parser_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (header_results_due.size() == 0) begin
                report_mismatch("result with nothing predicted", m_tdata[31:0], '0);
            end else begin
                want = header_results_due.pop_front();
                if (m_tdata[1:0] !== want.event_res) begin
                    report_mismatch("event_res", 32'(m_tdata[1:0]), 32'(want.event_res));
                end
                if (m_tdata[4:2] !== want.error_code) begin
                    report_mismatch("error_code", 32'(m_tdata[4:2]), 32'(want.error_code));
                end
                if (m_tdata[20:5] !== want.status_value) begin
                    report_mismatch("status_value", 32'(m_tdata[20:5]),
                                    32'(want.status_value));
                end
                if (m_tdata[52:21] !== want.body_length) begin
                    report_mismatch("body_length", m_tdata[52:21], want.body_length);
                end
                if (m_tdata[53] !== want.length_known) begin
                    report_mismatch("length_known", 32'(m_tdata[53]), 32'(want.length_known));
                end
                if (m_tdata[55:54] !== 2'b00) begin
                    report_mismatch("padding", 32'(m_tdata[55:54]), '0);
                end
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------------

    // wait until every queued transaction went in and its result came out
    task automatic drain();
        while (byte_stream.size() > 0 || s_tvalid || header_results_due.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int bytes);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        while (byte_stream.size() < bytes) begin
            queue_response();
        end
        drain();
    endtask

    initial begin
        restart_parser();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme bytes on a garbage line, then a protocol error
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, CHAR_LF);
        push_item(ACT_BYTE, "X");                // ignored after the error
        // restart carrying a full data byte, then a minimal response
        push_item(ACT_RESTART, 8'hFF);
        push_text("HTTP/1.0 204");
        push_item(ACT_BYTE, CHAR_CR);
        push_item(ACT_BYTE, CHAR_LF);
        push_item(ACT_BYTE, CHAR_LF);            // empty line ends the headers
        // empty line before any status
        push_item(ACT_RESTART, 8'h00);
        push_item(ACT_BYTE, CHAR_LF);
        push_item(ACT_RESTART, 8'h00);
        run_phase(0, 0, 0);

        // generated responses under each idling mix, draining in between
        run_phase(0, 0, 250);
        run_phase(78, 0, 250);
        run_phase(0, 78, 250);
        run_phase(26, 26, 250);

        // receiver holds off while the sender keeps offering
        hold_asked++;
        run_phase(0, 0, 100);

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("http_response_header_parser regression: pass");
        end else begin
            $display("http_response_header_parser regression: fail");
        end
        $finish;
    end

endmodule
